// ----- hw/rtl/dsm_pkg.sv -----
// ---------------------------------------------------------------------------
// dsm_pkg
// Shared types and constants for the dot-star pattern matcher.
// ---------------------------------------------------------------------------
package dsm_pkg;

  // Item kinds carried on the input tuser
  typedef enum logic [1:0] {
    FUNC_LOAD  = 2'd0,
    FUNC_START = 2'd1,
    FUNC_CHAR  = 2'd2,
    FUNC_NONE  = 2'd3
  } func_t;

  localparam logic [7:0] WILDCARD = 8'd46;  // '.'

  // Per-transfer control broadcast to every cell
  typedef struct packed {
    logic       load;       // write token at idx
    logic       start;      // reset active set to position zero
    logic       step;       // advance active set by text_char
    logic [4:0] idx;
    logic [7:0] tok_char;
    logic       tok_star;
    logic [7:0] text_char;
  } cell_ctrl_t;

endpackage

// ----- hw/rtl/dsm_cell.sv -----
// ---------------------------------------------------------------------------
// dsm_cell
// One pattern position: token storage, active bit, closure and step logic.
// ---------------------------------------------------------------------------
module dsm_cell import dsm_pkg::*; #(
  parameter int IDX   = 0,
  parameter int LEN_W = 6
) (
  input  logic             clk,
  input  logic             rst,
  input  cell_ctrl_t       ctrl,
  input  logic [LEN_W-1:0] len,
  input  logic             carry_in,   // star closure from previous cell
  input  logic             adv_in,     // previous cell consumed a char
  output logic             carry_out,
  output logic             adv_out,
  output logic             closed      // position active after closure
);

  logic [7:0] tok_char;
  logic       tok_star;
  logic       active;
  logic       pos_en;
  logic       tok_en;
  logic       hit;

  assign pos_en    = int'(len) >= IDX;
  assign tok_en    = int'(len) > IDX;
  assign closed    = pos_en & (active | carry_in);
  assign carry_out = closed & tok_star & tok_en;
  assign hit       = closed & tok_en &
                     ((tok_char == ctrl.text_char) || (tok_char == WILDCARD));
  assign adv_out   = hit & ~tok_star;

  // token store, no reset
  always_ff @(posedge clk) begin
    if (ctrl.load && (int'(ctrl.idx) == IDX)) begin
      tok_char <= ctrl.tok_char;
      tok_star <= ctrl.tok_star;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'(IDX == 0);
    end else if (ctrl.start) begin
      active <= 1'(IDX == 0);
    end else if (ctrl.step) begin
      active <= (hit & tok_star) | adv_in;
    end
  end

endmodule

// ----- hw/rtl/dot_star_pattern_matcher.sv -----
// ---------------------------------------------------------------------------
// dot_star_pattern_matcher
// Whole-string matcher for literal / '.' / starred tokens, one cell per token.
// ---------------------------------------------------------------------------
// Result path: a start or char transfer updates the active set; its result is
//   then registered into the output reg once that reg is free.
// Throughput: one transfer per cycle while no result is backed up; the star
//   closure ripples through the cell chain in the same cycle as the character step.
// Reset (rst, synchronous): active set back to position zero, length 0,
//   no result pending. Token storage keeps its contents.
module dot_star_pattern_matcher import dsm_pkg::*; #(
  parameter int MAX_TOKENS = 32
) (
  input  logic        clk,
  input  logic        rst,
  // config: pattern_length
  input  logic        cfg_wen,
  input  logic [5:0]  cfg_wdata,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // token_index[4:0], token_char[12:5],
                                      // token_star[13], text_char[21:14], 0
  input  logic [1:0]  s_axis_tuser,   // func[1:0]
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata    // matched[0], dead[1], 0
);

  localparam int LEN_W = $clog2(MAX_TOKENS + 1);

  logic [LEN_W-1:0]    len;         // saturated pattern length
  logic                final_act;   // "whole pattern consumed" position
  logic                pend;        // report owed for last accepted item
  logic                out_matched;
  logic                out_dead;

  logic                xfer_in;
  logic                out_free;
  logic                report;
  func_t               func;
  cell_ctrl_t          ctrl;

  logic [MAX_TOKENS-1:0] carry;
  logic [MAX_TOKENS-1:0] adv;
  logic [MAX_TOKENS:0]   closed;    // active set after star closure
  logic                  pend_next;

  // --- handshake -----------------------------------------------------------
  // Output register frees when empty or being drained; the pending stage
  // moves into it then, so a new transfer can enter behind it.
  assign out_free      = ~m_axis_tvalid | m_axis_tready;
  assign s_axis_tready = ~pend | out_free;
  assign xfer_in       = s_axis_tvalid & s_axis_tready;
  assign func          = func_t'(s_axis_tuser);

  always_comb begin
    ctrl           = '0;
    ctrl.idx       = s_axis_tdata[4:0];
    ctrl.tok_char  = s_axis_tdata[12:5];
    ctrl.tok_star  = s_axis_tdata[13];
    ctrl.text_char = s_axis_tdata[21:14];
    report         = 1'b0;
    case (func)
      FUNC_LOAD: begin
        ctrl.load = xfer_in;
      end
      FUNC_START: begin
        ctrl.start = xfer_in;
        report     = xfer_in;
      end
      FUNC_CHAR: begin
        ctrl.step = xfer_in;
        report    = xfer_in;
      end
      default: begin
        // unused kind: dropped, no result
      end
    endcase
  end

  // --- cell chain ----------------------------------------------------------
  // Cell i owns position i; closure carry and the advance bit ripple upward.
  for (genvar i = 0; i < MAX_TOKENS; i++) begin : g_cell
    logic cin;
    logic ain;
    if (i == 0) begin : g_head
      assign cin = 1'b0;
      assign ain = 1'b0;
    end else begin : g_link
      assign cin = carry[i-1];
      assign ain = adv[i-1];
    end

    dsm_cell #(
      .IDX   (i),
      .LEN_W (LEN_W)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctrl      (ctrl),
      .len       (len),
      .carry_in  (cin),
      .adv_in    (ain),
      .carry_out (carry[i]),
      .adv_out   (adv[i]),
      .closed    (closed[i])
    );
  end

  // final position exists only when the full token count is in use
  assign closed[MAX_TOKENS] = (len == LEN_W'(MAX_TOKENS)) &
                              (final_act | carry[MAX_TOKENS-1]);

  always_ff @(posedge clk) begin
    if (rst) begin
      final_act <= 1'b0;
    end else if (ctrl.start) begin
      final_act <= 1'b0;
    end else if (ctrl.step) begin
      final_act <= adv[MAX_TOKENS-1];
    end
  end

  // --- length register, saturated at write ---------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      len <= '0;
    end else if (cfg_wen) begin
      len <= (cfg_wdata > 6'(MAX_TOKENS)) ? LEN_W'(MAX_TOKENS) : LEN_W'(cfg_wdata);
    end
  end

  // --- report stage --------------------------------------------------------
  // The closure of the freshly updated set is evaluated once the output register
  // is free; tokens cannot change under it since any later load lands at
  // the same edge the report is taken or later.
  always_comb begin
    if (report) begin
      pend_next = 1'b1;
    end else if (out_free) begin
      pend_next = 1'b0;
    end else begin
      pend_next = pend;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend          <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      pend <= pend_next;
      if (out_free) begin
        m_axis_tvalid <= pend;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && pend) begin
      out_matched <= closed[len];
      out_dead    <= ~|closed;
    end
  end

  assign m_axis_tdata = {6'b0, out_dead, out_matched};

endmodule

// ----- hw/rtl/dsm_checker.sv -----
// ---------------------------------------------------------------------------
// dsm_checker
// Port-level checks for the dot-star pattern matcher, bound to the top level.
// ---------------------------------------------------------------------------
module dsm_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [7:0]  m_axis_tdata
);

  // nothing comes out right after reset
  a_reset_quiet: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result valid after reset");

  // input only stalls when a result is backed up
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("input stalled with empty output");

  // a full match always leaves at least one position active
  a_match_alive: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !(m_axis_tdata[0] && m_axis_tdata[1]))
    else $error("matched and dead both set");

  // held result keeps its value
  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

endmodule

bind dot_star_pattern_matcher dsm_checker u_dsm_checker (.*);

// ----- verif/tb_dot_star_pattern_matcher.sv -----
// ---------------------------------------------------------------------------
// tb_dot_star_pattern_matcher
// Self-checking bench for the dot-star pattern matcher. Pattern tokens,
// text starts and text characters go in on the input stream. A predictor
// tracks the active-position set of the pattern automaton and queues one
// matched/dead verdict per start or character transfer. Output transfers
// are checked in order. Sender gaps and receiver stalls are random.
// ---------------------------------------------------------------------------
module tb_dot_star_pattern_matcher import dsm_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_TOK = 32;
  localparam int ITEM_TARGET = 800;
  localparam int SETTLE_CYCLES = 4;   // extra wait after the last verdict

  typedef struct packed {
    bit matched;
    bit dead;
  } verdict_t;

  // -------------------------------------------------------------------------
  // Predictor and verdict checker
  // -------------------------------------------------------------------------
  class match_scoreboard;
    bit [8:0]    tokens [MAX_TOK];   // {star, char}
    logic [63:0] active;             // kept before the star closure
    int unsigned plen;
    verdict_t    pending_verdicts [$];
    int unsigned mismatches, verdicts_seen, match_cnt, dead_cnt;

    function new();
      active = 64'd1;
      plen = 0;
      mismatches = 0;
      verdicts_seen = 0;
      match_cnt = 0;
      dead_cnt = 0;
    endfunction

    function int unsigned used_len();
      return (plen > MAX_TOK) ? MAX_TOK : plen;
    endfunction

    // drop positions past the length, then let every active starred token
    // also enable the position after it (ascending, so chains propagate)
    function logic [63:0] star_closure(logic [63:0] s, int unsigned len);
      s &= (64'd1 << (len + 1)) - 64'd1;
      for (int i = 0; i < len; i++) begin
        if (s[i] && tokens[i][8]) s[i+1] = 1'b1;
      end
      return s;
    endfunction

    function void push_verdict();
      int unsigned len;
      logic [63:0] s;
      verdict_t v;
      len = used_len();
      s = star_closure(active, len);
      v.matched = s[len];
      v.dead = (s == 64'd0);
      pending_verdicts.push_back(v);
    endfunction

    function void note_length(bit [5:0] v);
      plen = v;
    endfunction

    function void note_transfer(func_t f, bit [4:0] idx, bit [7:0] tch, bit tst,
                                bit [7:0] ch);
      int unsigned len;
      logic [63:0] cur, nxt;
      case (f)
        FUNC_LOAD: tokens[idx] = {tst, tch};
        FUNC_START: begin
          active = 64'd1;
          push_verdict();
        end
        FUNC_CHAR: begin
          len = used_len();
          cur = star_closure(active, len);
          nxt = 64'd0;
          for (int i = 0; i < len; i++) begin
            if (cur[i] && (tokens[i][7:0] == ch || tokens[i][7:0] == WILDCARD)) begin
              if (tokens[i][8]) nxt[i] = 1'b1;      // starred: stay put
              else nxt[i+1] = 1'b1;                 // plain: move on
            end
          end
          active = nxt;
          push_verdict();
        end
        default: ;   // unused kind is dropped by the block
      endcase
    endfunction

    function void flag(string what, verdict_t e, bit m, bit d);
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: %s: expected matched=%0b dead=%0b, got matched=%0b dead=%0b",
                 $realtime, what, e.matched, e.dead, m, d);
    endfunction

    function void check_result(bit m, bit d);
      verdict_t e;
      verdicts_seen++;
      if (m) match_cnt++;
      if (d) dead_cnt++;
      if (pending_verdicts.size() == 0) begin
        e = '0;
        flag("result with nothing pending", e, m, d);
        return;
      end
      e = pending_verdicts.pop_front();
      if (m != e.matched || d != e.dead) flag("verdict mismatch", e, m, d);
    endfunction
  endclass

  // -------------------------------------------------------------------------
  // DUT and signals
  // -------------------------------------------------------------------------
  logic        clk;
  logic        rst;
  logic        cfg_wen;
  logic [5:0]  cfg_wdata;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata;   // token_index[4:0], token_char[12:5],
                               // token_star[13], text_char[21:14], 0
  logic [1:0]  s_axis_tuser;   // func[1:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [7:0]  m_axis_tdata;   // matched[0], dead[1], 0

  dot_star_pattern_matcher #(.MAX_TOKENS(MAX_TOK)) dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_wen       (cfg_wen),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  match_scoreboard sb = new();

  bit          calm;          // phase with no sender gaps and no stalls
  int unsigned item_cnt;      // accepted transfers that the block acts on
  int unsigned phase_cnt;
  bit [7:0]    pat_char [MAX_TOK];   // tokens as loaded, for text building
  bit          pat_star [MAX_TOK];

  // 8 ns clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Hard stop well beyond the slowest legal run
  initial begin
    #10_000_000;
    $display("[dot_star_pattern_matcher] ERROR");
    $finish;
  end

  // Mostly short gaps, a few long ones
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // -------------------------------------------------------------------------
  // Result side: random backpressure, check on every accepted transfer.
  // Sampling in the active region of posedge sees pre-edge values.
  // -------------------------------------------------------------------------
  initial begin
    int unsigned stall;
    stall = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        stall--;
      end else begin
        m_axis_tready <= 1'b1;
        if (!calm && $urandom_range(0, 3) == 0) stall = pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready)
      sb.check_result(m_axis_tdata[0], m_axis_tdata[1]);
  end

  // -------------------------------------------------------------------------
  // Input side. All tasks are entered and left at a falling edge; tvalid is
  // left high on return so back-to-back transfers need no gap.
  // -------------------------------------------------------------------------
  task automatic send_item(func_t f, bit [4:0] idx, bit [7:0] tch, bit tst,
                           bit [7:0] ch);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= f;
    s_axis_tdata  <= {2'b00, ch, tst, tch, idx};
    do @(posedge clk); while (!s_axis_tready);
    sb.note_transfer(f, idx, tch, tst, ch);
    if (f != FUNC_NONE) item_cnt++;
    @(negedge clk);
  endtask

  task automatic load_token(bit [4:0] idx, bit [7:0] ch, bit star);
    pat_char[idx] = ch;
    pat_star[idx] = star;
    send_item(FUNC_LOAD, idx, ch, star, 8'($urandom));
  endtask

  task automatic send_start();
    send_item(FUNC_START, 5'($urandom), 8'($urandom), 1'($urandom), 8'($urandom));
  endtask

  task automatic send_char(bit [7:0] ch);
    send_item(FUNC_CHAR, 5'($urandom), 8'($urandom), 1'($urandom), ch);
  endtask

  task automatic send_noise();
    send_item(FUNC_NONE, 5'($urandom), 8'($urandom), 1'($urandom), 8'($urandom));
  endtask

  // Block is idle once every verdict is in and trailing loads have landed
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (sb.pending_verdicts.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_length(bit [5:0] v);
    cfg_wdata <= v;
    cfg_wen   <= 1'b1;
    @(negedge clk);
    cfg_wen   <= 1'b0;
    sb.note_length(v);
  endtask

  // Small alphabet so that literal tokens actually hit
  function automatic bit [7:0] pick_text();
    if ($urandom_range(0, 99) < 80) return 8'h61 + 8'($urandom_range(0, 2));
    return 8'($urandom);
  endfunction

  function automatic bit [7:0] pick_token_char();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return 8'h61 + 8'($urandom_range(0, 2));
    if (r < 85) return WILDCARD;
    return 8'($urandom);
  endfunction

  // One phase: new length, fresh tokens, several texts. Texts are mostly
  // walked from the pattern (so they match), some mutated, some random.
  task automatic run_phase();
    int unsigned r, len, n, ntexts, reps, pos;
    bit [7:0] txt [$];
    calm = ($urandom_range(0, 4) == 0);
    case (phase_cnt)
      0: len = 63;   // saturates to the full token count
      1: len = 0;
      2: len = MAX_TOK;
      default: begin
        r = $urandom_range(0, 19);
        if (r == 0) len = 0;
        else if (r == 1) len = MAX_TOK;
        else if (r == 2) len = 63;
        else if (r == 3) len = $urandom_range(33, 62);
        else if (r < 8) len = $urandom_range(9, 31);
        else len = $urandom_range(1, 8);
      end
    endcase
    phase_cnt++;
    settle();
    write_length(6'(len));
    n = (len > MAX_TOK) ? MAX_TOK : len;
    // every token in use is written before anything reads it
    for (int i = 0; i < n; i++)
      load_token(5'(i), pick_token_char(), $urandom_range(0, 99) < 35);
    ntexts = $urandom_range(2, 6);
    for (int t = 0; t < ntexts; t++) begin
      // occasionally carry the old active set over into the new length
      if (t > 0 || $urandom_range(0, 9) != 0) send_start();
      txt.delete();
      if ($urandom_range(0, 99) < 65) begin
        for (int i = 0; i < n; i++) begin
          reps = pat_star[i] ? $urandom_range(0, 3) : 1;
          repeat (reps)
            txt.push_back(pat_char[i] == WILDCARD ? pick_text() : pat_char[i]);
        end
        if ($urandom_range(0, 99) < 30) begin
          r = $urandom_range(0, 2);
          if (r == 2 || txt.size() == 0) txt.push_back(pick_text());
          else begin
            pos = $urandom_range(0, txt.size() - 1);
            if (r == 0) txt[pos] = pick_text();
            else txt.delete(pos);
          end
        end
      end else begin
        repeat ($urandom_range(0, 10)) txt.push_back(pick_text());
      end
      foreach (txt[j]) begin
        r = $urandom_range(0, 99);
        // pattern edited mid-text takes effect on the next character
        if (r < 4) load_token(5'($urandom_range(0, 31)), pick_token_char(),
                              1'($urandom));
        else if (r < 7) send_noise();
        send_char(txt[j]);
      end
    end
  endtask

  // -------------------------------------------------------------------------
  // Main sequence
  // -------------------------------------------------------------------------
  initial begin
    int unsigned drain;
    rst           = 1'b1;
    cfg_wen       = 1'b0;
    cfg_wdata     = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = FUNC_NONE;
    calm          = 1'b0;
    item_cnt      = 0;
    phase_cnt     = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: empty pattern right after reset matches only empty text
    calm = 1'b1;
    send_start();
    send_char(8'h61);
    send_noise();
    // '.'* , literal zero byte, 0xFF* ; top index written too
    load_token(5'd0, WILDCARD, 1'b1);
    load_token(5'd1, 8'h00, 1'b0);
    load_token(5'd2, 8'hFF, 1'b1);
    load_token(5'd31, 8'h78, 1'b0);
    settle();
    write_length(6'd3);
    send_start();
    send_char(8'h00);     // zero byte hits the zero token
    send_char(8'hFF);
    send_char(8'h7F);     // falls back to the wildcard loop only
    send_char(8'h00);
    send_start();
    send_char(8'hAA);
    send_char(8'h55);

    // Random phases
    while (item_cnt < ITEM_TARGET) run_phase();

    // Drain, bounded
    s_axis_tvalid <= 1'b0;
    drain = 0;
    while (sb.pending_verdicts.size() != 0 && drain < 20000) begin
      @(negedge clk);
      drain++;
    end
    repeat (8) @(negedge clk);
    if (sb.pending_verdicts.size() != 0) begin
      $display("%0d verdicts never arrived", sb.pending_verdicts.size());
      sb.mismatches += sb.pending_verdicts.size();
    end

    $display("run: %0d transfers over %0d phases, lengths 0..63 incl. saturation",
             item_cnt, phase_cnt);
    $display("run: %0d verdicts checked, %0d matched, %0d dead, %0d mismatches",
             sb.verdicts_seen, sb.match_cnt, sb.dead_cnt, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("[dot_star_pattern_matcher] OK");
    end else begin
      $display("[dot_star_pattern_matcher] ERROR");
    end
    $finish;
  end

endmodule
